/* sv/ppve_pkg.sv */
// ppve_pkg: shared types, constants and codes for the visible-edge point projector.
// No dependencies; every other file refers to it by scoped names.
package ppve_pkg;

    localparam int MAX_SCREENS   = 8;
    localparam int COORD_BITS    = 16;
    localparam int DIM_BITS      = COORD_BITS - 1;
    localparam int WIDE_BITS     = COORD_BITS + 2;
    localparam int SLOT_BITS     = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
    localparam int CNT_BITS      = $clog2(MAX_SCREENS + 1);
    localparam int SIDES_BITS    = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = COORD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic [DIM_BITS-1:0]          dim_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;
    typedef logic [SLOT_BITS-1:0]         slot_idx_t;

    localparam wide_t COORD_HI = wide_t'((2 ** (COORD_BITS - 1)) - 1);
    localparam wide_t COORD_LO = wide_t'(-(2 ** (COORD_BITS - 1)));

    // edges kept pre-summed: right = x + w, bottom = y + h
    typedef struct packed {
        wide_t left;
        wide_t top;
        wide_t right;
        wide_t bottom;
    } screen_t;

    typedef screen_t [MAX_SCREENS-1:0] screen_arr_t;

    typedef struct packed {
        logic [SIDES_BITS-1:0] active_sides;
        dim_t                  band_size;
        coord_t                bounds_x;
        coord_t                bounds_y;
        dim_t                  bounds_w;
        dim_t                  bounds_h;
        cnt_t                  count;
    } cfg_t;

    typedef struct packed {
        logic   hit;
        coord_t value;
    } edge_res_t;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_BOTTOM = 2'd3
    } side_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ACTIVE_SIDES = 3'd0,
        REG_BAND_SIZE    = 3'd1,
        REG_BOUNDS_X     = 3'd2,
        REG_BOUNDS_Y     = 3'd3,
        REG_BOUNDS_W     = 3'd4,
        REG_BOUNDS_H     = 3'd5,
        REG_SCREEN_COUNT = 3'd6
    } cfg_idx_t;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

/* sv/ppve_cfg_regs.sv */
// ppve_cfg_regs: configuration register file with its own write channel.
// Depends on ppve_pkg.
module ppve_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppve_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ppve_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output ppve_pkg::cfg_t                       cfg
);

    logic [ppve_pkg::SIDES_BITS-1:0] sides_reg;
    ppve_pkg::dim_t                  band_reg;
    ppve_pkg::coord_t                bx_reg;
    ppve_pkg::coord_t                by_reg;
    ppve_pkg::dim_t                  bw_reg;
    ppve_pkg::dim_t                  bh_reg;
    logic [3:0]                      count_reg;
    logic                            wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sides_reg <= '0;
            band_reg  <= ppve_pkg::dim_t'(1);
            bx_reg    <= '0;
            by_reg    <= '0;
            bw_reg    <= '0;
            bh_reg    <= '0;
            count_reg <= '0;
        end
        else if (wr)
        begin
            case (ppve_pkg::cfg_idx_t'(cfg_index))
                ppve_pkg::REG_ACTIVE_SIDES: sides_reg <= cfg_data[ppve_pkg::SIDES_BITS-1:0];
                ppve_pkg::REG_BAND_SIZE:    band_reg  <= cfg_data[ppve_pkg::DIM_BITS-1:0];
                ppve_pkg::REG_BOUNDS_X:     bx_reg    <= ppve_pkg::coord_t'(cfg_data);
                ppve_pkg::REG_BOUNDS_Y:     by_reg    <= ppve_pkg::coord_t'(cfg_data);
                ppve_pkg::REG_BOUNDS_W:     bw_reg    <= cfg_data[ppve_pkg::DIM_BITS-1:0];
                ppve_pkg::REG_BOUNDS_H:     bh_reg    <= cfg_data[ppve_pkg::DIM_BITS-1:0];
                ppve_pkg::REG_SCREEN_COUNT: count_reg <= cfg_data[3:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.active_sides = sides_reg;
        cfg.band_size    = band_reg;
        cfg.bounds_x     = bx_reg;
        cfg.bounds_y     = by_reg;
        cfg.bounds_w     = bw_reg;
        cfg.bounds_h     = bh_reg;
        // count above table depth acts as full table
        if (32'(count_reg) > ppve_pkg::MAX_SCREENS)
            cfg.count = ppve_pkg::cnt_t'(ppve_pkg::MAX_SCREENS);
        else
            cfg.count = ppve_pkg::cnt_t'(count_reg);
    end

endmodule

/* sv/ppve_screen_table.sv */
// ppve_screen_table: screen rectangle table, one entry written per load beat.
// Depends on ppve_pkg. Entries have no reset.
module ppve_screen_table
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [2:0]             slot,
    input  ppve_pkg::coord_t       rect_x,
    input  ppve_pkg::coord_t       rect_y,
    input  ppve_pkg::dim_t         rect_w,
    input  ppve_pkg::dim_t         rect_h,
    output ppve_pkg::screen_arr_t  screens
);

    ppve_pkg::screen_arr_t table_reg;
    ppve_pkg::screen_t     new_entry;

    always_comb
    begin
        new_entry.left   = ppve_pkg::wide_t'(rect_x);
        new_entry.top    = ppve_pkg::wide_t'(rect_y);
        new_entry.right  = ppve_pkg::wide_t'(rect_x) + ppve_pkg::wide_t'(rect_w);
        new_entry.bottom = ppve_pkg::wide_t'(rect_y) + ppve_pkg::wide_t'(rect_h);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ppve_pkg::MAX_SCREENS; i++)
        begin
            if (we && (32'(slot) == i))
                table_reg[i] <= new_entry;
        end
    end

    assign screens = table_reg;

endmodule

/* sv/ppve_edge_unit.sv */
// ppve_edge_unit: shared edge test for one side and one candidate screen,
// with the neighbor-pixel occupancy check over all screens. Depends on ppve_pkg.
module ppve_edge_unit
(
    input  ppve_pkg::screen_arr_t  screens,
    input  ppve_pkg::cfg_t         cfg,
    input  ppve_pkg::side_t        side,
    input  ppve_pkg::slot_idx_t    idx,
    input  ppve_pkg::coord_t       px,
    input  ppve_pkg::coord_t       py,
    output ppve_pkg::edge_res_t    res
);

    ppve_pkg::wide_t   x;
    ppve_pkg::wide_t   y;
    ppve_pkg::wide_t   band;
    ppve_pkg::wide_t   cl, ct, cr, cb;
    ppve_pkg::wide_t   sl, st, sr, sb;
    ppve_pkg::wide_t   edge_w;
    logic              in_x, in_y, band_ok;
    logic [ppve_pkg::MAX_SCREENS-1:0] occ;

    always_comb
    begin
        x    = ppve_pkg::wide_t'(px);
        y    = ppve_pkg::wide_t'(py);
        band = (cfg.band_size == '0) ? ppve_pkg::wide_t'(1)
                                     : ppve_pkg::wide_t'(cfg.band_size);
        cl   = screens[idx].left;
        ct   = screens[idx].top;
        cr   = screens[idx].right;
        cb   = screens[idx].bottom;
        in_x = (x >= cl) && (x < cr);
        in_y = (y >= ct) && (y < cb);

        case (side)
            ppve_pkg::SIDE_LEFT:   band_ok = in_y && (x >= cl) && (x < cl + band);
            ppve_pkg::SIDE_RIGHT:  band_ok = in_y && (x >= cr - band) && (x < cr);
            ppve_pkg::SIDE_TOP:    band_ok = in_x && (y >= ct) && (y < ct + band);
            default:               band_ok = in_x && (y >= cb - band) && (y < cb);
        endcase

        // pixel just outside the edge, tested against every valid screen
        for (int s = 0; s < ppve_pkg::MAX_SCREENS; s++)
        begin
            sl = screens[s].left;
            st = screens[s].top;
            sr = screens[s].right;
            sb = screens[s].bottom;
            case (side)
                ppve_pkg::SIDE_LEFT:
                    occ[s] = (cl > sl) && (cl <= sr) && (y >= st) && (y < sb);
                ppve_pkg::SIDE_RIGHT:
                    occ[s] = (cr >= sl) && (cr < sr) && (y >= st) && (y < sb);
                ppve_pkg::SIDE_TOP:
                    occ[s] = (x >= sl) && (x < sr) && (ct > st) && (ct <= sb);
                default:
                    occ[s] = (x >= sl) && (x < sr) && (cb >= st) && (cb < sb);
            endcase
            occ[s] = occ[s] && (32'(cfg.count) > s);
        end

        case (side)
            ppve_pkg::SIDE_LEFT:
                edge_w = ppve_pkg::wide_t'(cfg.bounds_x);
            ppve_pkg::SIDE_RIGHT:
                edge_w = ppve_pkg::wide_t'(cfg.bounds_x) + ppve_pkg::wide_t'(cfg.bounds_w)
                         - ppve_pkg::wide_t'(1);
            ppve_pkg::SIDE_TOP:
                edge_w = ppve_pkg::wide_t'(cfg.bounds_y);
            default:
                edge_w = ppve_pkg::wide_t'(cfg.bounds_y) + ppve_pkg::wide_t'(cfg.bounds_h)
                         - ppve_pkg::wide_t'(1);
        endcase

        res.hit = band_ok && !(|occ);
        if (edge_w > ppve_pkg::COORD_HI)
            res.value = ppve_pkg::COORD_HI[ppve_pkg::COORD_BITS-1:0];
        else if (edge_w < ppve_pkg::COORD_LO)
            res.value = ppve_pkg::COORD_LO[ppve_pkg::COORD_BITS-1:0];
        else
            res.value = edge_w[ppve_pkg::COORD_BITS-1:0];
    end

endmodule

/* sv/ppve_seq.sv */
// ppve_seq: query sequencer stepping sides and screens through the edge unit,
// holding the working point and issuing the result strobe. Depends on ppve_pkg.
module ppve_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   query_go,
    input  ppve_pkg::coord_t       point_x,
    input  ppve_pkg::coord_t       point_y,
    input  ppve_pkg::cfg_t         cfg,
    input  ppve_pkg::edge_res_t    res,
    output ppve_pkg::side_t        side,
    output ppve_pkg::slot_idx_t    idx,
    output ppve_pkg::coord_t       px,
    output ppve_pkg::coord_t       py,
    output logic                   busy,
    output logic                   done,
    output logic                   moved
);

    ppve_pkg::state_t    state_reg,  state_next;
    ppve_pkg::side_t     side_reg,   side_next;
    ppve_pkg::slot_idx_t idx_reg,    idx_next;
    ppve_pkg::coord_t    px_reg,     px_next;
    ppve_pkg::coord_t    py_reg,     py_next;
    logic                moved_reg,  moved_next;
    logic                done_reg,   done_next;
    logic                run, adv_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppve_pkg::ST_IDLE;
            side_reg  <= ppve_pkg::SIDE_LEFT;
            idx_reg   <= '0;
            moved_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            idx_reg   <= idx_next;
            moved_reg <= moved_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        idx_next   = idx_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        moved_next = moved_reg;
        done_next  = 1'b0;
        run        = cfg.active_sides[side_reg] && (ppve_pkg::cnt_t'(idx_reg) < cfg.count);
        adv_side   = !run || res.hit
                     || (ppve_pkg::cnt_t'(idx_reg) + ppve_pkg::cnt_t'(1) >= cfg.count);

        case (state_reg)
            ppve_pkg::ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = ppve_pkg::ST_RUN;
                    side_next  = ppve_pkg::SIDE_LEFT;
                    idx_next   = '0;
                    px_next    = point_x;
                    py_next    = point_y;
                    moved_next = 1'b0;
                end
            end
            ppve_pkg::ST_RUN:
            begin
                if (run && res.hit)
                begin
                    if ((side_reg == ppve_pkg::SIDE_LEFT) || (side_reg == ppve_pkg::SIDE_RIGHT))
                    begin
                        px_next    = res.value;
                        moved_next = moved_reg || (px_reg != res.value);
                    end
                    else
                    begin
                        py_next    = res.value;
                        moved_next = moved_reg || (py_reg != res.value);
                    end
                end
                if (adv_side)
                begin
                    idx_next = '0;
                    if (side_reg == ppve_pkg::SIDE_BOTTOM)
                    begin
                        state_next = ppve_pkg::ST_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        side_next = ppve_pkg::side_t'(side_reg + 2'd1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + ppve_pkg::slot_idx_t'(1);
                end
            end
            default:
            begin
                state_next = ppve_pkg::ST_IDLE;
            end
        endcase
    end

    assign side  = side_reg;
    assign idx   = idx_reg;
    assign px    = px_reg;
    assign py    = py_reg;
    assign busy  = (state_reg != ppve_pkg::ST_IDLE);
    assign done  = done_reg;
    assign moved = moved_reg;

endmodule

/* sv/project_point_to_visible_edge_top.sv */
// Visible-edge point projector, top level. A load beat writes one table entry and gives
// no result. A query beat steps the sides in order, passing over a side that is disabled
// or has no valid screens, else testing screens one at a time up to the first hit, all
// through the single shared edge unit; busy is high throughout and done pulses for one
// cycle as busy falls. The receiver cannot stall.
// Reset (rst_n, async) clears control and config registers; table entries are not reset.
module project_point_to_visible_edge_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [2:0]                          slot,
    input  ppve_pkg::coord_t                    rect_x,
    input  ppve_pkg::coord_t                    rect_y,
    input  ppve_pkg::dim_t                      rect_w,
    input  ppve_pkg::dim_t                      rect_h,
    input  ppve_pkg::coord_t                    point_x,
    input  ppve_pkg::coord_t                    point_y,
    output logic                                done,
    output ppve_pkg::coord_t                    out_x,
    output ppve_pkg::coord_t                    out_y,
    output logic                                moved,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppve_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ppve_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    ppve_pkg::cfg_t        cfg;
    ppve_pkg::screen_arr_t screens;
    ppve_pkg::edge_res_t   res;
    ppve_pkg::side_t       side;
    ppve_pkg::slot_idx_t   idx;
    ppve_pkg::coord_t      px;
    ppve_pkg::coord_t      py;
    logic                  accept;
    logic                  load_we;
    logic                  query_go;

    assign accept   = start && !busy;
    assign load_we  = accept && (mode == ppve_pkg::MODE_LOAD);
    assign query_go = accept && (mode == ppve_pkg::MODE_QUERY);

    ppve_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ppve_screen_table u_table
    (
        .clk     (clk),
        .we      (load_we),
        .slot    (slot),
        .rect_x  (rect_x),
        .rect_y  (rect_y),
        .rect_w  (rect_w),
        .rect_h  (rect_h),
        .screens (screens)
    );

    ppve_edge_unit u_edge
    (
        .screens (screens),
        .cfg     (cfg),
        .side    (side),
        .idx     (idx),
        .px      (px),
        .py      (py),
        .res     (res)
    );

    ppve_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .query_go (query_go),
        .point_x  (point_x),
        .point_y  (point_y),
        .cfg      (cfg),
        .res      (res),
        .side     (side),
        .idx      (idx),
        .px       (px),
        .py       (py),
        .busy     (busy),
        .done     (done),
        .moved    (moved)
    );

    assign out_x = px;
    assign out_y = py;

endmodule

/* sv/ppve_checker.sv */
// ppve_checker: port-level checks of the command handshake and result strobe,
// bound to project_point_to_visible_edge_top. Depends on ppve_pkg.
module ppve_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic mode,
    input  logic done
);

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding query run");

    a_query_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == ppve_pkg::MODE_QUERY)) |=> busy)
        else $error("query beat did not start a run");

    a_load_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == ppve_pkg::MODE_LOAD)) |=> (!busy && !done))
        else $error("load beat started a run or produced a result");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("run ended without a result beat");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind project_point_to_visible_edge_top ppve_checker u_ppve_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .done  (done)
);
